>>> hw/rtl/cau_pkg.sv
// cau_pkg: widths, operation codes, the lane word that flows down the cell row,
// and the sign-magnitude helpers shared by the complex arithmetic unit.
// No dependencies.
package cau_pkg;

	localparam int W  = 32;              // word bits of every operand and result part
	localparam int F  = 16;              // fraction bits
	localparam int TB = 16;              // tolerance register bits
	localparam int NB = 2 * W + 1;       // sum of two products
	localparam int QB = NB + F;          // scaled dividend, one cell per quotient bit
	localparam int RB = (NB + 1) / 2;    // root bits of a sum of squares

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MOD = 3'd4
	} op_t;

	typedef struct packed {
		logic            vld;
		logic [2:0]      op;
		logic            neg_re;
		logic            neg_im;
		logic            dz;
		logic [NB-1:0]   den;
		logic [NB-1:0]   rem_re;
		logic [NB-1:0]   rem_im;
		logic [QB-1:0]   qn_re;
		logic [QB-1:0]   qn_im;
		logic [2*RB-1:0] rad;
		logic [RB:0]     srem;
		logic [RB-1:0]   root;
	} lane_t;

	// signed add of two sign-magnitude products, result {neg, magnitude}
	function automatic logic [NB:0] sm_add(input logic [2*W-1:0] x, input logic nx,
			input logic [2*W-1:0] y, input logic ny);
		logic [NB-1:0] xe;
		logic [NB-1:0] ye;
		logic [NB:0]   r;
		xe = {1'b0, x};
		ye = {1'b0, y};
		if (nx == ny) begin
			r = {nx, xe + ye};
		end else if (xe >= ye) begin
			r = {nx, xe - ye};
		end else begin
			r = {ny, ye - xe};
		end
		return r;
	endfunction

	// clamp a magnitude to the word range, result {overflow, word}
	function automatic logic [W:0] sat(input logic [QB-1:0] m, input logic neg);
		logic [QB-1:0] lim;
		logic [QB-1:0] v;
		logic          ovf;
		lim = neg ? QB'({1'b1, {(W-1){1'b0}}}) : QB'({1'b0, {(W-1){1'b1}}});
		ovf = (m > lim);
		v   = ovf ? lim : m;
		v   = neg ? (QB'(0) - v) : v;
		return {ovf, v[W-1:0]};
	endfunction

endpackage

>>> hw/rtl/cau_if.sv
// cau_in_if / cau_out_if: valid-ready channels of the complex arithmetic unit.
// Depends on cau_pkg for the word width.
interface cau_in_if
	import cau_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [2:0]          operation;
	logic signed [W-1:0] a_real;
	logic signed [W-1:0] a_imag;
	logic signed [W-1:0] b_real;
	logic signed [W-1:0] b_imag;

	modport source(output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
	modport sink(input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if
	import cau_pkg::*;
();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] result_real;
	logic signed [W-1:0] result_imag;
	logic                divide_by_zero;
	logic                overflow;

	modport source(output valid, result_real, result_imag, divide_by_zero, overflow,
		input ready);
	modport sink(input valid, result_real, result_imag, divide_by_zero, overflow,
		output ready);
endinterface

>>> hw/rtl/cau_front.sv
// cau_front: operand split, products and sums ahead of the cell row (three stages).
// Depends on cau_pkg.
module cau_front
	import cau_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_vld,
	input  logic [TB-1:0]       tol,
	input  logic [2:0]          operation,
	input  logic signed [W-1:0] a_real,
	input  logic signed [W-1:0] a_imag,
	input  logic signed [W-1:0] b_real,
	input  logic signed [W-1:0] b_imag,
	output lane_t               lane
);

	function automatic logic [W-1:0] mag(input logic [W-1:0] x);
		return x[W-1] ? (W'(0) - x) : x;
	endfunction

	// stage 1
	logic           vld_s1, dz_s1;
	logic [2:0]     op_s1;
	logic [W-1:0]   ar_s1, ai_s1, br_s1, bi_s1;
	logic           nar_s1, nai_s1, nbr_s1, nbi_s1;
	logic [W+1:0]   sre_s1, sim_s1;
	// stage 2
	logic           vld_s2, dz_s2;
	logic [2:0]     op_s2;
	logic           nar_s2, nai_s2, nbr_s2, nbi_s2;
	logic [W+1:0]   sre_s2, sim_s2;
	logic [2*W-1:0] prr_s2, pii_s2, pri_s2, pir_s2, sqx_s2, sqy_s2;
	// stage 3
	logic           vld_s3;
	lane_t          lane_s3, lane_n;

	logic [W-1:0]   mbr, mbi;
	logic [W+1:0]   ae_re, ae_im, be_re, be_im;
	logic           sub;

	assign mbr   = mag(b_real);
	assign mbi   = mag(b_imag);
	assign sub   = (operation == OP_SUB);
	assign ae_re = {{2{a_real[W-1]}}, a_real};
	assign ae_im = {{2{a_imag[W-1]}}, a_imag};
	assign be_re = {{2{b_real[W-1]}}, b_real};
	assign be_im = {{2{b_imag[W-1]}}, b_imag};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= operation;
			ar_s1  <= mag(a_real);
			ai_s1  <= mag(a_imag);
			br_s1  <= mbr;
			bi_s1  <= mbi;
			nar_s1 <= a_real[W-1];
			nai_s1 <= a_imag[W-1];
			nbr_s1 <= b_real[W-1];
			nbi_s1 <= b_imag[W-1];
			sre_s1 <= ae_re + (sub ? ((W+2)'(0) - be_re) : be_re);
			sim_s1 <= ae_im + (sub ? ((W+2)'(0) - be_im) : be_im);
			dz_s1  <= (mbr < W'(tol) && mbi < W'(tol)) || (mbr == '0 && mbi == '0);

			op_s2  <= op_s1;
			dz_s2  <= dz_s1;
			nar_s2 <= nar_s1;
			nai_s2 <= nai_s1;
			nbr_s2 <= nbr_s1;
			nbi_s2 <= nbi_s1;
			sre_s2 <= sre_s1;
			sim_s2 <= sim_s1;
			prr_s2 <= (2*W)'(ar_s1) * (2*W)'(br_s1);
			pii_s2 <= (2*W)'(ai_s1) * (2*W)'(bi_s1);
			pri_s2 <= (2*W)'(ar_s1) * (2*W)'(bi_s1);
			pir_s2 <= (2*W)'(ai_s1) * (2*W)'(br_s1);
			// modulus squares A, everything else squares B
			sqx_s2 <= (op_s1 == OP_MOD) ? (2*W)'(ar_s1) * (2*W)'(ar_s1)
			                            : (2*W)'(br_s1) * (2*W)'(br_s1);
			sqy_s2 <= (op_s1 == OP_MOD) ? (2*W)'(ai_s1) * (2*W)'(ai_s1)
			                            : (2*W)'(bi_s1) * (2*W)'(bi_s1);

			lane_s3 <= lane_n;
		end
	end

	always_comb begin
		logic [NB:0]   mre, mim, dre, dim;
		logic [NB-1:0] sqs;
		logic [W+1:0]  are, aim;
		mre = sm_add(prr_s2, nar_s2 ^ nbr_s2, pii_s2, !(nai_s2 ^ nbi_s2));
		mim = sm_add(pri_s2, nar_s2 ^ nbi_s2, pir_s2, nai_s2 ^ nbr_s2);
		dre = sm_add(prr_s2, nar_s2 ^ nbr_s2, pii_s2, nai_s2 ^ nbi_s2);
		dim = sm_add(pir_s2, nai_s2 ^ nbr_s2, pri_s2, !(nar_s2 ^ nbi_s2));
		sqs = {1'b0, sqx_s2} + {1'b0, sqy_s2};
		are = sre_s2[W+1] ? ((W+2)'(0) - sre_s2) : sre_s2;
		aim = sim_s2[W+1] ? ((W+2)'(0) - sim_s2) : sim_s2;
		lane_n    = '0;
		lane_n.op = op_s2;
		lane_n.dz = dz_s2 && (op_s2 == OP_DIV);
		case (op_s2)
			OP_ADD, OP_SUB: begin
				lane_n.neg_re = sre_s2[W+1];
				lane_n.neg_im = sim_s2[W+1];
				lane_n.qn_re  = QB'(are);
				lane_n.qn_im  = QB'(aim);
			end
			OP_MUL: begin
				lane_n.neg_re = mre[NB];
				lane_n.neg_im = mim[NB];
				lane_n.qn_re  = QB'(mre[NB-1:0] >> F);
				lane_n.qn_im  = QB'(mim[NB-1:0] >> F);
			end
			OP_DIV: begin
				lane_n.neg_re = dre[NB];
				lane_n.neg_im = dim[NB];
				lane_n.den    = sqs;
				lane_n.qn_re  = {dre[NB-1:0], {F{1'b0}}};
				lane_n.qn_im  = {dim[NB-1:0], {F{1'b0}}};
			end
			OP_MOD: begin
				lane_n.rad = (2*RB)'(sqs);
			end
			default: ;
		endcase
	end

	always_comb begin
		lane     = lane_s3;
		lane.vld = vld_s3;
	end

endmodule

>>> hw/rtl/cau_cell.sv
// cau_cell: one cell of the row; one restoring quotient bit for each part of a
// divide, or one root bit of a modulus. Depends on cau_pkg.
module cau_cell
	import cau_pkg::*;
#(
	parameter int STEP = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  lane_t din,
	output lane_t dout
);

	lane_t nxt, word_q;
	logic  vld_q;

	always_comb begin
		logic [NB:0]   rr_re, rr_im, de, df_re, df_im;
		logic          ge_re, ge_im, ge_rt;
		logic [RB+2:0] t, trial, df_rt;
		nxt   = din;
		de    = {1'b0, din.den};
		rr_re = {din.rem_re, din.qn_re[QB-1]};
		rr_im = {din.rem_im, din.qn_im[QB-1]};
		ge_re = (rr_re >= de);
		ge_im = (rr_im >= de);
		df_re = rr_re - de;
		df_im = rr_im - de;
		t     = {din.srem, din.rad[2*RB-1 -: 2]};
		trial = (RB+3)'({din.root, 2'b01});
		ge_rt = (t >= trial);
		df_rt = t - trial;
		if (din.op == OP_DIV) begin
			nxt.rem_re = ge_re ? df_re[NB-1:0] : rr_re[NB-1:0];
			nxt.rem_im = ge_im ? df_im[NB-1:0] : rr_im[NB-1:0];
			nxt.qn_re  = {din.qn_re[QB-2:0], ge_re};
			nxt.qn_im  = {din.qn_im[QB-2:0], ge_im};
		end
		// root bits run out before quotient bits: later cells hold the root
		if (din.op == OP_MOD && STEP < RB) begin
			nxt.srem = ge_rt ? df_rt[RB:0] : t[RB:0];
			nxt.root = {din.root[RB-2:0], ge_rt};
			nxt.rad  = din.rad << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_q <= nxt;
		end
	end

	always_comb begin
		dout     = word_q;
		dout.vld = vld_q;
	end

endmodule

>>> hw/rtl/complex_number_alu.sv
// complex_number_alu: Q16.16 complex add, subtract, multiply, divide and modulus.
// Three front stages, 81 cells (one per quotient bit), one output register.
// Throughput one word per cycle; the whole row advances together while the output is free.
// Reset clears every valid bit and sets zero_tolerance to 1; payload is not reset.
// Depends on cau_pkg, cau_if, cau_front and cau_cell.
module complex_number_alu
	import cau_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	cau_in_if.sink      req,
	cau_out_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Config register: zero_tolerance at byte address 0.
	logic [TB-1:0] tol_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {{(32-TB){1'b0}}, tol_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TB'(1);
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			tol_q <= pwdata[TB-1:0];
		end
	end

	// Advance the whole pipe whenever the output register is empty or being drained;
	// hold everything otherwise.
	logic adv;
	logic out_vld_q;

	assign adv       = !out_vld_q || rsp.ready;
	assign req.ready = adv;

	// Front end feeds cell 0; each cell hands its word to the next every cycle while the pipe advances.
	lane_t chain [QB+1];

	cau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_vld    (req.valid),
		.tol       (tol_q),
		.operation (req.operation),
		.a_real    (req.a_real),
		.a_imag    (req.a_imag),
		.b_real    (req.b_real),
		.b_imag    (req.b_imag),
		.lane      (chain[0])
	);

	for (genvar g = 0; g < QB; g++) begin : g_cell
		cau_cell #(.STEP(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.din    (chain[g]),
			.dout   (chain[g+1])
		);
	end

	// Output stage: pick the magnitude per operation, then saturate each part.
	lane_t          tail;
	logic [QB-1:0]  m_re, m_im;
	logic           n_re, n_im, dz_n;
	logic [W:0]     s_re, s_im;
	logic [W-1:0]   re_q, im_q;
	logic           dz_q, ovf_q;

	assign tail = chain[QB];

	always_comb begin
		m_re = '0;
		m_im = '0;
		n_re = 1'b0;
		n_im = 1'b0;
		dz_n = 1'b0;
		case (tail.op)
			OP_ADD, OP_SUB, OP_MUL: begin
				m_re = tail.qn_re;
				m_im = tail.qn_im;
				n_re = tail.neg_re;
				n_im = tail.neg_im;
			end
			OP_DIV: begin
				// a zero divisor drops the quotients and raises its flag
				dz_n = tail.dz;
				if (!tail.dz) begin
					m_re = tail.qn_re;
					m_im = tail.qn_im;
					n_re = tail.neg_re;
					n_im = tail.neg_im;
				end
			end
			OP_MOD: begin
				m_re = QB'(tail.root);
			end
			default: ;
		endcase
		s_re = sat(m_re, n_re);
		s_im = sat(m_im, n_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= tail.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			re_q  <= s_re[W-1:0];
			im_q  <= s_im[W-1:0];
			dz_q  <= dz_n;
			ovf_q <= s_re[W] | s_im[W];
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.result_real    = re_q;
	assign rsp.result_imag    = im_q;
	assign rsp.divide_by_zero = dz_q;
	assign rsp.overflow       = ovf_q;

	// A zero divisor always returns a clean zero word.
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.divide_by_zero |->
			rsp.result_real == '0 && rsp.result_imag == '0 && !rsp.overflow)
		else $error("divide by zero word carries data");

	// A blocked output must stall the input side.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("input accepted while output stalled");

	// Overflow implies some part sits at a range limit.
	a_ovf_lim: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.overflow |->
			rsp.result_real == {1'b1, {(W-1){1'b0}}} ||
			rsp.result_real == {1'b0, {(W-1){1'b1}}} ||
			rsp.result_imag == {1'b1, {(W-1){1'b0}}} ||
			rsp.result_imag == {1'b0, {(W-1){1'b1}}})
		else $error("overflow without saturated part");

endmodule

>>> sim/complex_number_alu_chk.sv
// complex_number_alu_chk: watches the request, response and register channels,
// predicts each result word and compares it field by field. Depends on cau_pkg, cau_if.
`timescale 1ns / 100ps
module complex_number_alu_chk
	import cau_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	cau_in_if           req,
	cau_out_if          rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);

	localparam logic [2:0] ADDR_ZERO_TOL = 3'd0;

	typedef struct {
		logic signed [W-1:0] re;
		logic signed [W-1:0] im;
		logic                dz;
		logic                ovf;
	} cplx_result_t;

	typedef logic signed [129:0] wide_t;

	cplx_result_t result_q[$];
	logic [TB-1:0] tol;

	function automatic wide_t floor_root(input wide_t s);
		wide_t r;
		wide_t c;
		r = 0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (wide_t'(1) << b);
			if (c * c <= s) r = c;
		end
		return r;
	endfunction

	function automatic logic signed [W-1:0] clamp(input wide_t v, inout logic ovf);
		if (v > wide_t'(32'sh7fffffff)) begin
			ovf = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -(wide_t'(1) << 31)) begin
			ovf = 1'b1;
			return 32'sh80000000;
		end
		return v[W-1:0];
	endfunction

	function automatic cplx_result_t alu_result(input logic [2:0] op,
			input logic signed [W-1:0] ar, input logic signed [W-1:0] ai,
			input logic signed [W-1:0] br, input logic signed [W-1:0] bi,
			input logic [TB-1:0] zt);
		cplx_result_t r;
		wide_t xr, xi, yr, yi, re, im, den, mbr, mbi;
		xr = ar; xi = ai; yr = br; yi = bi;
		re = 0; im = 0;
		r.dz = 1'b0;
		r.ovf = 1'b0;
		case (op)
			OP_ADD: begin re = xr + yr; im = xi + yi; end
			OP_SUB: begin re = xr - yr; im = xi - yi; end
			OP_MUL: begin
				re = (xr * yr - xi * yi) / 65536;
				im = (xr * yi + xi * yr) / 65536;
			end
			OP_DIV: begin
				den = yr * yr + yi * yi;
				mbr = yr < 0 ? -yr : yr;
				mbi = yi < 0 ? -yi : yi;
				if ((mbr < zt && mbi < zt) || den == 0) begin
					r.dz = 1'b1;
				end else begin
					re = ((xr * yr + xi * yi) * 65536) / den;
					im = ((xi * yr - xr * yi) * 65536) / den;
				end
			end
			OP_MOD: re = floor_root(xr * xr + xi * xi);
			default: ;
		endcase
		r.re = clamp(re, r.ovf);
		r.im = clamp(im, r.ovf);
		return r;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("%0t: %s got %0h want %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cplx_result_t e;
		if (!arst_n) begin
			tol <= 1;
			fail_count = 0;
			result_q.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_ZERO_TOL)
				tol <= pwdata[TB-1:0];
			if (req.valid && req.ready)
				result_q.push_back(alu_result(req.operation, req.a_real, req.a_imag,
					req.b_real, req.b_imag, tol));
			if (rsp.valid && rsp.ready) begin
				if (result_q.size() == 0) begin
					report("unexpected word", rsp.result_real, 0);
				end else begin
					e = result_q.pop_front();
					if (rsp.result_real !== e.re) report("result_real", rsp.result_real, e.re);
					if (rsp.result_imag !== e.im) report("result_imag", rsp.result_imag, e.im);
					if (rsp.divide_by_zero !== e.dz)
						report("divide_by_zero", rsp.divide_by_zero, e.dz);
					if (rsp.overflow !== e.ovf) report("overflow", rsp.overflow, e.ovf);
				end
			end
		end
		pending = result_q.size();
	end

endmodule

>>> sim/complex_number_alu_tb.sv
// complex_number_alu_tb: drives requests, response stalls and tolerance writes into
// the complex arithmetic unit; the checker predicts. Depends on cau_pkg, cau_if, the RTL.
`timescale 1ns / 100ps
module complex_number_alu_tb;
	import cau_pkg::*;

	localparam logic [2:0] ADDR_ZERO_TOL = 3'd0;
	localparam int         DRAIN_CYCLES  = 100;   // pipeline is 85 deep
	localparam int         CYCLE_LIMIT   = 400000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	int          fail_count, pending, cycles;
	int          send_idle, recv_stall;  // percent: gap chance after each sent word, stall chance per cycle

	cau_in_if  req_ch();
	cau_out_if rsp_ch();

	complex_number_alu uut (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	complex_number_alu_chk chk (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hold ready low at random to stall the result side
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	// abort if the run hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("complex_number_alu: mismatch");
			$finish;
		end
	end

	// operand mix: full range, modest values, extremes, and values near the tolerance
	function automatic logic signed [W-1:0] pick_part();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed(W'($urandom_range(0, 32'h003fffff))) - 32'sh00200000;
			2: case ($urandom_range(0, 4))
				0: return 0;
				1: return 1;
				2: return -1;
				3: return 32'sh7fffffff;
				default: return 32'sh80000000;
			endcase
			default: return $signed(W'($urandom_range(0, 400))) - 200;
		endcase
	endfunction

	task automatic send_word(input logic [2:0] op, input logic signed [W-1:0] ar,
			input logic signed [W-1:0] ai, input logic signed [W-1:0] br,
			input logic signed [W-1:0] bi);
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.a_real    <= ar;
		req_ch.a_imag    <= ai;
		req_ch.b_real    <= br;
		req_ch.b_imag    <= bi;
		do @(posedge clk); while (!req_ch.ready);
		// drop valid for a random gap now and then
		if ($urandom_range(0, 99) < send_idle) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic send_random();
		logic [2:0] op;
		op = ($urandom_range(0, 19) == 0) ? 3'(OP_MOD + $urandom_range(1, 3))
			: 3'($urandom_range(OP_ADD, OP_MOD));
		send_word(op, pick_part(), pick_part(), pick_part(), pick_part());
	endtask

	// let the pipe empty, then write the tolerance over a setup and an access phase
	task automatic write_tolerance(input logic [15:0] value);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_ZERO_TOL;
		pwdata  <= {16'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int idle_mode[4][2] = '{'{0, 0}, '{48, 0}, '{0, 48}, '{22, 22}};
		logic [15:0] tol_set[4] = '{16'd65535, 16'd1, 16'd300, 16'd0};
		send_idle   = 0;
		recv_stall  = 0;
		arst_n      = 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.operation <= '0;
		req_ch.a_real    <= '0;
		req_ch.a_imag    <= '0;
		req_ch.b_real    <= '0;
		req_ch.b_imag    <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at the reset tolerance of one LSB
		send_word(OP_ADD, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
		send_word(OP_SUB, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
		send_word(OP_ADD, 32'sh00010000, -32'sh00010000, 32'sh00020000, 32'sh00030000);
		send_word(OP_MUL, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
		send_word(OP_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_word(OP_MUL, 32'sh00018000, -32'sh00008000, -32'sh00000001, 32'sh00000003);
		send_word(OP_DIV, 32'sh00010000, 32'sh00020000, 32'sh0, 32'sh0);
		send_word(OP_DIV, 32'sh00010000, 32'sh00020000, 32'sh1, 32'sh0);
		send_word(OP_DIV, 32'sh7fffffff, 32'sh80000000, 32'sh1, -32'sh1);
		send_word(OP_DIV, -32'sh00030000, 32'sh00010000, 32'sh00020000, -32'sh00010000);
		send_word(OP_DIV, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_word(OP_MOD, 32'sh0, 32'sh0, 32'sh7fffffff, 32'sh7fffffff);
		send_word(OP_MOD, 32'sh80000000, 32'sh80000000, 32'sh0, 32'sh0);
		send_word(OP_MOD, 32'sh00030000, -32'sh00040000, 32'sh1, 32'sh1);
		send_word(OP_MOD, 32'sh7fffffff, 32'sh0, 32'sh0, 32'sh0);
		send_word(3'(OP_MOD + 1), 32'sh7fffffff, -32'sh1, 32'sh5, 32'sh5);
		send_word(3'(OP_MOD + 3), -32'sh1, -32'sh1, -32'sh1, -32'sh1);

		// tolerance at its maximum: small divisors on both sides of the limit
		write_tolerance(16'd65535);
		send_word(OP_DIV, 32'sh00010000, 32'sh00010000, 32'sh0000fffe, -32'sh0000fffe);
		send_word(OP_DIV, 32'sh00010000, 32'sh00010000, 32'sh0000ffff, 32'sh0);
		send_word(OP_DIV, 32'sh00010000, 32'sh00010000, -32'sh00010000, 32'sh0);

		for (int ph = 0; ph < 4; ph++) begin
			write_tolerance(ph == 3 ? 16'($urandom_range(1, 65535)) : tol_set[ph]);
			send_idle  = idle_mode[ph][0];
			recv_stall = idle_mode[ph][1];
			repeat (232) send_random();
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("complex_number_alu: match");
		end else begin
			$display("complex_number_alu: mismatch");
		end
		$finish;
	end

endmodule
